// File: rtl/wbps_pkg.sv
// package for the wildcard byte pattern scan core
// holds configuration register indexes, field widths and parameter defaults
// no dependencies
`default_nettype none

package wbps_pkg;

    localparam int MAX_PATTERN_BYTES_DEF = 16;
    localparam int PATTERN_STORE_BYTES   = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int ADDR_W      = 64;
    localparam int PLEN_W      = 5;
    localparam int WILD_W      = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW   = 3'd0,
        REG_PATTERN_HIGH  = 3'd1,
        REG_WILDCARD_BITS = 3'd2,
        REG_PATTERN_LEN   = 3'd3,
        REG_BASE_ADDRESS  = 3'd4
    } cfg_reg_t;

endpackage

`default_nettype wire

// File: rtl/wildcard_byte_pattern_scan_core.sv
// The input register takes an accepted byte; the result register loads from it once the result side is free.
// Throughput: one byte item per cycle while the result side does not stall; set by the single window shift and
// parallel compare stage between the input register and the result register.
// Reset: asynchronous active low; clears valids, region state and sets
// configuration registers to their reset values (pattern_len 1, others 0).
// depends on wbps_pkg
`default_nettype none

module wildcard_byte_pattern_scan_core
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   byte_valid,
    output logic                        byte_stall,
    input  wire logic [7:0]             mem_byte,
    input  wire logic                   is_last,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output logic                        found,
    output logic [ADDR_W-1:0]           match_address,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int CMP_W = (LEN_W > PLEN_W) ? LEN_W : PLEN_W;
    localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;
    logic [WILD_W-1:0]     wildcard_bits_reg;
    logic [PLEN_W-1:0]     pattern_len_reg;
    logic [ADDR_W-1:0]     base_address_reg;

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    logic [7:0]        window_reg  [MAX_PATTERN_BYTES];
    logic [7:0]        window_next [MAX_PATTERN_BYTES];
    logic [ADDR_W-1:0] seen_reg, seen_next;
    logic              reported_reg, reported_next;

    logic              out_valid_reg, out_valid_next;
    logic              found_reg, found_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;

    logic [7:0] pat_byte [MAX_PATTERN_BYTES];
    logic       pat_wild [MAX_PATTERN_BYTES];

    logic [CMP_W-1:0]  plen_ext;
    logic [LEN_W-1:0]  len_eff;
    logic              out_free;
    logic              advance;
    logic              accept;
    logic              mismatch;
    logic              enough;
    logic [ADDR_W-1:0] seen_inc;

    // pattern bytes beyond the stored sixteen are zero and never wild
    for (genvar g = 0; g < MAX_PATTERN_BYTES; g++) begin : g_pat
        if (g < PATTERN_STORE_BYTES / 2) begin : g_low
            assign pat_byte[g] = pattern_low_reg[8*g +: 8];
            assign pat_wild[g] = wildcard_bits_reg[g];
        end
        else if (g < PATTERN_STORE_BYTES) begin : g_high
            assign pat_byte[g] = pattern_high_reg[8*(g-8) +: 8];
            assign pat_wild[g] = wildcard_bits_reg[g];
        end
        else begin : g_none
            assign pat_byte[g] = 8'd0;
            assign pat_wild[g] = 1'b0;
        end
    end

    always_comb
    begin
        plen_ext = CMP_W'(pattern_len_reg);
        if (plen_ext == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (plen_ext > CMP_W'(MAX_PATTERN_BYTES))
        begin
            len_eff = LEN_W'(MAX_PATTERN_BYTES);
        end
        else
        begin
            len_eff = LEN_W'(plen_ext);
        end
    end

    assign out_free   = !out_valid_reg || !result_stall;
    assign advance    = s1_valid_reg && out_free;
    assign byte_stall = s1_valid_reg && !out_free;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        logic [LEN_W-1:0] pos;
        window_next[0] = s1_byte_reg;
        for (int i = 1; i < MAX_PATTERN_BYTES; i++)
        begin
            window_next[i] = window_reg[i-1];
        end
        seen_inc = seen_reg + ADDR_W'(1);
        enough   = seen_inc >= ADDR_W'(len_eff);
        mismatch = 1'b0;
        pos      = '0;
        for (int k = 0; k < MAX_PATTERN_BYTES; k++)
        begin
            if (LEN_W'(k) < len_eff && !pat_wild[k])
            begin
                pos = LEN_W'(len_eff - LEN_W'(1) - LEN_W'(k));
                if (window_next[pos[IDX_W-1:0]] != pat_byte[k])
                begin
                    mismatch = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        seen_next      = seen_reg;
        reported_next  = reported_reg;
        found_next     = found_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg && result_stall;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
        if (advance)
        begin
            if (!reported_reg)
            begin
                seen_next = seen_inc;
                if (enough && !mismatch)
                begin
                    reported_next  = 1'b1;
                    out_valid_next = 1'b1;
                    found_next     = 1'b1;
                    addr_next      = base_address_reg + seen_reg
                                     - ADDR_W'(len_eff - LEN_W'(1));
                end
                else if (s1_last_reg)
                begin
                    out_valid_next = 1'b1;
                    found_next     = 1'b0;
                    addr_next      = '0;
                end
            end
            if (s1_last_reg)
            begin
                seen_next     = '0;
                reported_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg   <= '0;
            pattern_high_reg  <= '0;
            wildcard_bits_reg <= '0;
            pattern_len_reg   <= PLEN_W'(1);
            base_address_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_PATTERN_LOW:   pattern_low_reg   <= cfg_wr_data;
                REG_PATTERN_HIGH:  pattern_high_reg  <= cfg_wr_data;
                REG_WILDCARD_BITS: wildcard_bits_reg <= cfg_wr_data[WILD_W-1:0];
                REG_PATTERN_LEN:   pattern_len_reg   <= cfg_wr_data[PLEN_W-1:0];
                REG_BASE_ADDRESS:  base_address_reg  <= cfg_wr_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            seen_reg      <= '0;
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            seen_reg      <= seen_next;
            reported_reg  <= reported_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= mem_byte;
            s1_last_reg <= is_last;
        end
        if (advance && !reported_reg)
        begin
            for (int i = 0; i < MAX_PATTERN_BYTES; i++)
            begin
                window_reg[i] <= window_next[i];
            end
        end
        found_reg <= found_next;
        addr_reg  <= addr_next;
    end

    assign result_valid  = out_valid_reg;
    assign found         = found_reg;
    assign match_address = addr_reg;

endmodule

`default_nettype wire

// File: rtl/wbps_checker.sv
// port level checks for the wildcard byte pattern scan core
// bound to wildcard_byte_pattern_scan_core; no package dependency
`default_nettype none

module wbps_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        byte_stall,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire logic        found,
    input wire logic [63:0] match_address
);

    // a held result keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(found)
            && $stable(match_address))
        else $error("result changed while stalled");

    // not found always reports address zero
    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !found |-> match_address == 64'd0)
        else $error("not found result with nonzero address");

    // input side only backs up when the result side does
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> result_valid && result_stall)
        else $error("input stalled with free result register");

    // nothing pending once reset has been held low
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n ##1 !rst_n |-> !result_valid && !byte_stall)
        else $error("activity during reset");

endmodule

bind wildcard_byte_pattern_scan_core wbps_checker u_wbps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_stall    (byte_stall),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .found         (found),
    .match_address (match_address)
);

`default_nettype wire

// File: bench/wbps_scan_checker.sv
// checker for the wildcard byte pattern scan core: follows configuration writes,
// predicts the found / not-found result of every region and compares results
// depends on wbps_pkg
`timescale 1ns / 1ps

module wbps_scan_checker
    import wbps_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   byte_valid,
    input  wire logic                   byte_stall,
    input  wire logic [7:0]             mem_byte,
    input  wire logic                   is_last,
    input  wire logic                   result_valid,
    input  wire logic                   result_stall,
    input  wire logic                   found,
    input  wire logic [ADDR_W-1:0]      match_address,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data,
    output int                          fail_count,
    output int                          pending,
    output int                          results_checked,
    output int                          hits_checked
);

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] addr;
    } scan_result_t;

    scan_result_t expected_results[$];

    logic [127:0]      pattern_bytes;
    logic [WILD_W-1:0] wild_mask;
    logic [PLEN_W-1:0] len_reg;
    logic [ADDR_W-1:0] base_reg;

    logic [7:0]        window [16];
    logic [63:0]       region_count;
    logic              hit_done;

    function automatic int used_length();
        if (len_reg == '0)
            return 1;
        if (len_reg > 5'd16)
            return 16;
        return int'(len_reg);
    endfunction

    function automatic logic window_hit(int n);
        logic hit;
        hit = 1'b1;
        for (int k = 0; k < n; k++)
            if (!wild_mask[k] && window[n-1-k] != pattern_bytes[8*k +: 8])
                hit = 1'b0;
        return hit;
    endfunction

    task automatic clear_region();
        for (int i = 0; i < 16; i++)
            window[i] = 8'h00;
        region_count = '0;
        hit_done = 1'b0;
    endtask

    task automatic take_byte(input logic [7:0] b, input logic last);
        int n;
        scan_result_t r;
        n = used_length();
        if (!hit_done)
        begin
            for (int i = 15; i > 0; i--)
                window[i] = window[i-1];
            window[0] = b;
            region_count = region_count + 64'd1;
            if (region_count >= 64'(n) && window_hit(n))
            begin
                hit_done = 1'b1;
                r.found = 1'b1;
                r.addr = base_reg + (region_count - 64'(n));
                expected_results.push_back(r);
            end
            else if (last)
            begin
                r.found = 1'b0;
                r.addr = '0;
                expected_results.push_back(r);
            end
        end
        if (last)
            clear_region();
    endtask

    task automatic note_mismatch(input string what, input logic [ADDR_W-1:0] exp_v,
                                 input logic [ADDR_W-1:0] act_v);
        if (fail_count < 10)
            $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, exp_v, act_v);
        fail_count <= fail_count + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        scan_result_t want;
        if (!rst_n)
        begin
            pattern_bytes = '0;
            wild_mask = '0;
            len_reg = 5'd1;
            base_reg = '0;
            clear_region();
            expected_results.delete();
            fail_count <= 0;
            pending <= 0;
            results_checked <= 0;
            hits_checked <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_checked <= results_checked + 1;
                if (expected_results.size() == 0)
                begin
                    note_mismatch("unexpected result (found, address)", '0,
                                  {found, match_address[ADDR_W-2:0]});
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.found)
                        hits_checked <= hits_checked + 1;
                    if (found !== want.found)
                        note_mismatch("found", ADDR_W'(want.found), ADDR_W'(found));
                    else if (match_address !== want.addr)
                        note_mismatch("match_address", want.addr, match_address);
                end
            end
            if (byte_valid && !byte_stall)
                take_byte(mem_byte, is_last);
            if (cfg_wr_en)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_PATTERN_LOW:   pattern_bytes[63:0] = cfg_wr_data;
                    REG_PATTERN_HIGH:  pattern_bytes[127:64] = cfg_wr_data;
                    REG_WILDCARD_BITS: wild_mask = cfg_wr_data[WILD_W-1:0];
                    REG_PATTERN_LEN:   len_reg = cfg_wr_data[PLEN_W-1:0];
                    REG_BASE_ADDRESS:  base_reg = cfg_wr_data;
                    default: ;
                endcase
            end
            pending <= expected_results.size();
        end
    end

endmodule

// File: bench/testbench.sv
// top of the scan core testbench: clock, reset, configuration writes and byte stimulus
// with random pacing on both channels; depends on wbps_pkg, the core and wbps_scan_checker
`timescale 1ns / 1ps

module testbench;
    import wbps_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   byte_valid = 1'b0;
    logic                   byte_stall;
    logic [7:0]             mem_byte = 8'h00;
    logic                   is_last = 1'b0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic                   found;
    logic [ADDR_W-1:0]      match_address;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;

    int fail_count;
    int pending;
    int results_checked;
    int hits_checked;

    bit steady = 1'b0;
    bit drain = 1'b0;

    logic [127:0]      cur_pattern = '0;
    logic [WILD_W-1:0] cur_wild = '0;
    logic [PLEN_W-1:0] cur_len = 5'd1;

    int bytes_sent = 0;
    int regions_closed = 0;
    int settings_used = 1;

    wildcard_byte_pattern_scan_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .mem_byte      (mem_byte),
        .is_last       (is_last),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .found         (found),
        .match_address (match_address),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    wbps_scan_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_valid      (byte_valid),
        .byte_stall      (byte_stall),
        .mem_byte        (mem_byte),
        .is_last         (is_last),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .found           (found),
        .match_address   (match_address),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .hits_checked    (hits_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin : run_limit
        #(4_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic int used_length();
        if (cur_len == '0)
            return 1;
        if (cur_len > 5'd16)
            return 16;
        return int'(cur_len);
    endfunction

    // receiver pacing
    initial
    begin : result_pacing
        int gap;
        forever
        begin
            repeat ($urandom_range(8, 1)) @(posedge clk);
            gap = pick_gap();
            if (!drain && gap > 0)
            begin
                result_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        mem_byte <= b;
        is_last <= last;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        bytes_sent++;
        if (last)
            regions_closed++;
    endtask

    task automatic settle();
        byte_valid <= 1'b0;
        drain = 1'b1;
        @(posedge clk);
        while (pending != 0 || result_stall)
            @(posedge clk);
        repeat (8) @(posedge clk);
        drain = 1'b0;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_setting(input logic [63:0] pat_lo, input logic [63:0] pat_hi,
                                input logic [63:0] wild, input logic [63:0] len,
                                input logic [63:0] base);
        settle();
        write_reg(REG_PATTERN_LOW, pat_lo);
        write_reg(REG_PATTERN_HIGH, pat_hi);
        write_reg(REG_WILDCARD_BITS, wild);
        write_reg(REG_PATTERN_LEN, len);
        write_reg(REG_BASE_ADDRESS, base);
        cur_pattern = {pat_hi, pat_lo};
        cur_wild = wild[WILD_W-1:0];
        cur_len = len[PLEN_W-1:0];
        settings_used++;
    endtask

    function automatic logic [7:0] filler_byte(int plen);
        if ($urandom_range(1))
            return cur_pattern[8*$urandom_range(plen-1) +: 8];
        return 8'($urandom_range(255));
    endfunction

    // one region: background bytes with a planted, damaged or cut-off pattern, or with none
    task automatic run_region(input bit close);
        int n;
        int plen;
        int at;
        int mode;
        int k;
        logic [7:0] region_bytes[$];
        plen = used_length();
        mode = $urandom_range(99);
        if ($urandom_range(9) == 0)
            n = $urandom_range(3, 1);
        else
            n = plen + $urandom_range(12);
        for (int i = 0; i < n; i++)
            region_bytes.push_back(filler_byte(plen));
        if (mode < 70 && n >= plen)
        begin
            at = $urandom_range(n - plen);
            for (int j = 0; j < plen; j++)
                if (!cur_wild[j])
                    region_bytes[at+j] = cur_pattern[8*j +: 8];
            if (mode >= 50)
            begin
                k = $urandom_range(plen - 1);
                region_bytes[at+k] = region_bytes[at+k] ^ (8'h01 << $urandom_range(7));
            end
        end
        else if (mode < 85 && plen > 1)
        begin
            at = n - plen + $urandom_range(plen - 1, 1);
            if (at < 0)
                at = 0;
            for (int j = 0; j < plen && at + j < n; j++)
                if (!cur_wild[j])
                    region_bytes[at+j] = cur_pattern[8*j +: 8];
        end
        for (int i = 0; i < n; i++)
            send_byte(region_bytes[i], close && i == n - 1);
    endtask

    initial
    begin : stimulus
        logic [63:0] len_v;
        logic [63:0] wild_v;
        logic [63:0] base_v;
        int phase_items;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: one pattern byte 00, match on the final byte
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);

        // length zero acts as one, address wraps, bytes after a match are ignored
        load_setting(64'h0000_0000_0000_00AB, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
                     64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_byte(8'h12, 1'b0);
        send_byte(8'hAB, 1'b0);
        send_byte(8'h55, 1'b1);

        // full length, all wildcards, then a region too short to hold the pattern
        load_setting(64'h8877_6655_4433_2211, 64'hFF00_FF00_FF00_FF00, 64'hFFFF,
                     64'd16, 64'h0000_0000_0000_1000);
        for (int i = 0; i < 16; i++)
            send_byte((i % 2) ? 8'hFF : 8'h00, i == 15);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h3C, 1'b1);

        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: len_v = 64'd1;
                1: len_v = 64'd16;
                2: len_v = 64'd0;
                3: len_v = 64'd31;
                4: len_v = 64'd2;
                default: len_v = 64'($urandom_range(15, 1));
            endcase
            if (ph == 1)
                wild_v = 64'h0;
            else if (ph == 5)
                wild_v = 64'({$urandom, 16'hFFFF});
            else if (ph == 8)
                wild_v = {$urandom, $urandom};
            else
                wild_v = 64'($urandom & $urandom & 32'hFFFF);
            if (ph == 8)
                len_v = len_v | 64'({$urandom, 27'h0});
            case (ph)
                0: base_v = 64'h0;
                3: base_v = 64'hFFFF_FFFF_FFFF_FFF8;
                6: base_v = 64'hFFFF_FFFF_FFFF_FFFF;
                default: base_v = {$urandom, $urandom};
            endcase
            load_setting({$urandom, $urandom}, {$urandom, $urandom}, wild_v, len_v, base_v);
            steady = (ph % 4 == 2);
            phase_items = bytes_sent;
            while (bytes_sent - phase_items < 45)
                run_region(bytes_sent - phase_items < 32 || $urandom_range(4) != 0);
            steady = 1'b0;
        end

        settle();
        repeat (10) @(posedge clk);
        $display("sent %0d bytes in %0d closed regions over %0d settings", bytes_sent,
                 regions_closed, settings_used);
        $display("checked %0d results, %0d of them matches", results_checked, hits_checked);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
rtl/wbps_pkg.sv
rtl/wildcard_byte_pattern_scan_core.sv
rtl/wbps_checker.sv
bench/wbps_scan_checker.sv
bench/testbench.sv
